### hdl/efl_pkg.sv
// efl_pkg: shared types, constants and helpers for the energy FIR level meter.
// No dependencies; imported by efl_ctrl, efl_datapath and energy_fir_level_meter.
`default_nettype none

package efl_pkg;

    localparam int TAPS_DEF       = 50;
    localparam int DECIMATION_DEF = 50;
    localparam int COEF_WIDTH_DEF = 16;

    localparam int SAMPLE_W   = 12;
    localparam int SQ_W       = 24;
    localparam int IDX_W      = 6;
    localparam int CVAL_W     = 16;
    localparam int ACC_W      = 48;
    localparam int BAR_W      = 8;
    localparam int LEVEL_W    = 3;
    localparam int THR_W      = 35;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 56;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_DATA_W-1:0] FIRST_THRESHOLD_RST = 32'd5000;
    localparam logic [CFG_DATA_W-1:0] THRESHOLD_STEP_RST  = 32'd15000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FIRST_THRESHOLD = 1'b0,
        CFG_THRESHOLD_STEP  = 1'b1
    } cfg_reg_t;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    typedef struct packed {
        logic                 smp_wr;
        logic                 coef_wr;
        logic                 mac_step;
        logic                 mac_first;
        logic                 thr_step;
        logic                 thr_first;
        logic                 emit;
        logic [LEVEL_W-1:0]   level;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

    // bar pattern for level i: i+1 low bits set
    function automatic logic [BAR_W-1:0] thermo(input logic [LEVEL_W-1:0] lvl);
        logic [BAR_W-1:0] one_hot;
        one_hot = BAR_W'(8'd2) << lvl;
        return one_hot - BAR_W'(1);
    endfunction

endpackage

`default_nettype wire

### hdl/efl_ctrl.sv
// efl_ctrl: sequencer for the level meter (accept, MAC walk, drain, threshold scan, emit).
// Depends on efl_pkg; drives efl_datapath through cmd_t, reads sts_t.
`default_nettype none

module efl_ctrl #(
    parameter int TAPS       = efl_pkg::TAPS_DEF,
    parameter int DECIMATION = efl_pkg::DECIMATION_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    input  wire logic          opcode,
    output logic               s_tready,
    output efl_pkg::cmd_t      cmd,
    input  wire efl_pkg::sts_t sts
);
    import efl_pkg::*;

    localparam int PW = $clog2(DECIMATION + 1);
    localparam int CW = ($clog2(TAPS) > LEVEL_W) ? $clog2(TAPS) : LEVEL_W;
    localparam int DRAIN_CYCLES = 2;
    localparam int LEVELS = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_THRESH,
        ST_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [PW-1:0]   phase_reg, phase_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            accept;
    logic            last_phase;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign last_phase = (phase_reg == PW'(DECIMATION - 1));

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        cmd.level  = cnt_reg[LEVEL_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_COEF)
                    begin
                        cmd.coef_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.smp_wr = 1'b1;
                        if (last_phase)
                        begin
                            phase_next = '0;
                            cnt_next   = '0;
                            state_next = ST_MAC;
                        end
                        else
                        begin
                            phase_next = phase_reg + PW'(1);
                        end
                    end
                end
            end
            ST_MAC:
            begin
                cmd.mac_step  = 1'b1;
                cmd.mac_first = (cnt_reg == '0);
                if (cnt_reg == CW'(TAPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (cnt_reg == CW'(DRAIN_CYCLES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_THRESH;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_THRESH:
            begin
                cmd.thr_step  = 1'b1;
                cmd.thr_first = (cnt_reg == '0);
                if (cnt_reg == CW'(LEVELS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC && cnt_reg == CW'(TAPS - 1)) |=> (state_reg == ST_DRAIN))
        else $error("MAC walk did not end after the last tap");

    a_block_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_SAMPLE && last_phase) |=>
        (state_reg == ST_MAC && phase_reg == '0))
        else $error("decimation boundary did not start a MAC walk");

endmodule

`default_nettype wire

### hdl/efl_datapath.sv
// efl_datapath: tap and coefficient memories, MAC pipeline, threshold scan, output register.
// Depends on efl_pkg; commanded by efl_ctrl.
`default_nettype none

module efl_datapath #(
    parameter int TAPS       = efl_pkg::TAPS_DEF,
    parameter int COEF_WIDTH = efl_pkg::COEF_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [efl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [efl_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [efl_pkg::IN_DATA_W-1:0]     in_data,
    input  wire efl_pkg::cmd_t                     cmd,
    output efl_pkg::sts_t                          sts,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [efl_pkg::OUT_DATA_W-1:0]         m_tdata,
    output logic                                   m_tuser
);
    import efl_pkg::*;

    localparam int AW = $clog2(TAPS);
    localparam int PW = SQ_W + 1 + COEF_WIDTH;

    logic [SAMPLE_W-1:0]         sample;
    logic [IDX_W-1:0]            coef_index;
    logic signed [CVAL_W-1:0]    coef_value;
    logic [SQ_W-1:0]             square;
    logic signed [COEF_WIDTH-1:0] coef_trunc;
    logic                        coef_ok;
    logic [AW-1:0]               coef_addr;

    logic [SQ_W-1:0]              sq_mem [TAPS];
    logic signed [COEF_WIDTH-1:0] cf_mem [TAPS];
    logic [TAPS-1:0]              sq_vld_reg;
    logic [TAPS-1:0]              cf_vld_reg;

    logic [AW-1:0]   wptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   cf_ptr_reg;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   cf_addr;
    logic [AW-1:0]   wptr_inc;
    logic [AW-1:0]   rd_inc;
    logic [AW-1:0]   cf_inc;

    logic [SQ_W-1:0]              sq_rd_reg;
    logic signed [COEF_WIDTH-1:0] cf_rd_reg;
    logic                         sq_ok_reg;
    logic                         cf_ok_reg;
    logic                         s1_valid_reg;
    logic                         s2_valid_reg;
    logic [SQ_W-1:0]              sq_op;
    logic signed [COEF_WIDTH-1:0] cf_op;
    logic signed [PW-1:0]         prod_reg;
    logic signed [ACC_W-1:0]      acc_reg;

    logic [CFG_DATA_W-1:0] first_reg;
    logic [CFG_DATA_W-1:0] step_reg;
    logic [THR_W-1:0]      thr_reg;
    logic [THR_W-1:0]      thr_cur;
    logic                  exceed;
    logic [BAR_W-1:0]      bar_reg;
    logic                  hit_reg;

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                  m_tuser_reg;

    assign sample     = in_data[11:0];
    assign coef_index = in_data[17:12];
    assign coef_value = signed'(in_data[33:18]);

    assign square     = {{(SQ_W - SAMPLE_W){1'b0}}, sample} * {{(SQ_W - SAMPLE_W){1'b0}}, sample};
    assign coef_trunc = COEF_WIDTH'(coef_value);
    assign coef_ok    = ({3'b000, coef_index} < 9'(TAPS));
    assign coef_addr  = AW'(coef_index);

    // walk starts at the oldest entry, which pairs with coefficient 0
    assign rd_addr  = cmd.mac_first ? wptr_reg : rd_ptr_reg;
    assign cf_addr  = cmd.mac_first ? '0 : cf_ptr_reg;
    assign wptr_inc = (wptr_reg == AW'(TAPS - 1)) ? '0 : wptr_reg + AW'(1);
    assign rd_inc   = (rd_addr == AW'(TAPS - 1)) ? '0 : rd_addr + AW'(1);
    assign cf_inc   = (cf_addr == AW'(TAPS - 1)) ? '0 : cf_addr + AW'(1);

    assign sq_op = sq_ok_reg ? sq_rd_reg : '0;
    assign cf_op = cf_ok_reg ? cf_rd_reg : '0;

    assign thr_cur = cmd.thr_first ? {3'b000, first_reg} : thr_reg;
    assign exceed  = !acc_reg[ACC_W-1] &&
                     (acc_reg > signed'({{(ACC_W - THR_W){1'b0}}, thr_cur}));

    always_ff @(posedge clk)
    begin
        if (cmd.smp_wr)
        begin
            sq_mem[wptr_reg] <= square;
        end
        if (cmd.coef_wr && coef_ok)
        begin
            cf_mem[coef_addr] <= coef_trunc;
        end
        if (cmd.mac_step)
        begin
            sq_rd_reg <= sq_mem[rd_addr];
            cf_rd_reg <= cf_mem[cf_addr];
        end
        prod_reg <= $signed({1'b0, sq_op}) * cf_op;
        if (cmd.thr_step)
        begin
            thr_reg <= thr_cur + {3'b000, step_reg};
        end
        if (cmd.emit)
        begin
            m_tdata_reg <= {acc_reg, bar_reg};
            m_tuser_reg <= hit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg   <= '0;
            cf_vld_reg   <= '0;
            wptr_reg     <= '0;
            rd_ptr_reg   <= '0;
            cf_ptr_reg   <= '0;
            sq_ok_reg    <= 1'b0;
            cf_ok_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            acc_reg      <= '0;
            first_reg    <= FIRST_THRESHOLD_RST;
            step_reg     <= THRESHOLD_STEP_RST;
            bar_reg      <= '0;
            hit_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FIRST_THRESHOLD: first_reg <= cfg_data;
                    CFG_THRESHOLD_STEP:  step_reg  <= cfg_data;
                    default:             ;
                endcase
            end
            if (cmd.smp_wr)
            begin
                sq_vld_reg[wptr_reg] <= 1'b1;
                wptr_reg             <= wptr_inc;
            end
            if (cmd.coef_wr && coef_ok)
            begin
                cf_vld_reg[coef_addr] <= 1'b1;
            end
            if (cmd.mac_step)
            begin
                sq_ok_reg  <= sq_vld_reg[rd_addr];
                cf_ok_reg  <= cf_vld_reg[cf_addr];
                rd_ptr_reg <= rd_inc;
                cf_ptr_reg <= cf_inc;
            end
            s1_valid_reg <= cmd.mac_step;
            s2_valid_reg <= s1_valid_reg;
            if (cmd.mac_first)
            begin
                acc_reg <= '0;
            end
            else if (s2_valid_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            if (cmd.thr_step)
            begin
                if (exceed)
                begin
                    bar_reg <= thermo(cmd.level);
                end
                hit_reg <= cmd.thr_first ? exceed : (hit_reg || exceed);
            end
            if (cmd.emit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign m_tuser      = m_tuser_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_tvalid_reg || m_tready))
        else $error("result emitted over an unaccepted beat");

    a_bar_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.thr_step |=> $stable(bar_reg))
        else $error("bar changed outside the threshold scan");

    a_bar_thermo: assert property (@(posedge clk) disable iff (!rst_n)
        ((bar_reg + 8'd1) & bar_reg) == 8'd0)
        else $error("bar register is not a thermometer pattern");

endmodule

`default_nettype wire

### hdl/energy_fir_level_meter.sv
// energy_fir_level_meter: top level, joins the sequencer and the datapath.
// Depends on efl_pkg, efl_ctrl, efl_datapath.
//
// Input stream (s_axis): tuser = opcode (0 sample, 1 coefficient load). Each
// sample is squared into a TAPS-deep tap memory; a coefficient beat writes one
// entry of the coefficient memory (index >= TAPS ignored). Every DECIMATION-th
// sample starts a MAC walk over all TAPS entries of the single-port tap and
// coefficient memories, then a drain of the multiply pipeline, a threshold
// scan over the 8 levels and the load of the output register, after which the
// result beat (m_axis) is valid. s_axis_tready is low from the acceptance of
// that sample until the output register is loaded.
// Result tdata = {energy, bar_pattern}, tuser = bar_updated.
// A stalled result sits in the output register; samples keep being accepted
// until the next walk finishes, which then waits for the slot to free.
// Reset clears the tap and coefficient memories (per-entry valid bits), the
// decimation phase and the bar, and loads thresholds 5000 / 15000.
`default_nettype none

module energy_fir_level_meter #(
    parameter int TAPS       = efl_pkg::TAPS_DEF,
    parameter int DECIMATION = efl_pkg::DECIMATION_DEF,
    parameter int COEF_WIDTH = efl_pkg::COEF_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [efl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [efl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // sample[11:0], coef_index[17:12], coef_value[33:18], zero pad [39:34]
    input  wire logic [efl_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // opcode[0]
    input  wire logic [0:0]                      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // bar_pattern[7:0], energy[55:8]
    output logic [efl_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // bar_updated[0]
    output logic [0:0]                           m_axis_tuser
);
    import efl_pkg::*;

    cmd_t cmd;
    sts_t sts;

    efl_ctrl #(
        .TAPS       (TAPS),
        .DECIMATION (DECIMATION)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .opcode   (s_axis_tuser[0]),
        .s_tready (s_axis_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    efl_datapath #(
        .TAPS       (TAPS),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .m_tuser   (m_axis_tuser[0])
    );

endmodule

`default_nettype wire

### verif/tb_energy_fir_level_meter.sv
// tb_energy_fir_level_meter: self-checking bench for the energy FIR level meter.
// Depends on efl_pkg and energy_fir_level_meter. Sample and coefficient beats are
// mirrored into an in-bench meter; each decimation result is checked on m_axis.

module tb_energy_fir_level_meter;
    timeunit 1ns;
    timeprecision 1ps;

    import efl_pkg::*;

    localparam int TAPS        = TAPS_DEF;
    localparam int DECIMATION  = DECIMATION_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic                     op;
        logic [SAMPLE_W-1:0]      smp;
        logic [IDX_W-1:0]         idx;
        logic signed [CVAL_W-1:0] val;
    } meter_in_t;

    typedef struct packed {
        logic [BAR_W-1:0]        bar;
        logic signed [ACC_W-1:0] energy;
        logic                    upd;
    } reading_t;

    typedef struct packed {
        meter_in_t beat;
        int        reps;
        logic      fixed;
        reading_t  rd;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic [0:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    // bench copy of the meter state
    logic [SQ_W-1:0]          sq_line [TAPS];
    logic signed [CVAL_W-1:0] coef_tab [TAPS];
    int                       dec_phase;
    logic [BAR_W-1:0]         bar_reg;
    logic [CFG_DATA_W-1:0]    thr_first;
    logic [CFG_DATA_W-1:0]    thr_step;

    reading_t readings_due [$];
    dir_row_t dir_rows [0:13];

    int   tx_idle_pct  = 8;
    int   rx_idle_pct  = 72;
    int   mismatch_cnt = 0;
    int   cycle_cnt    = 0;
    int   hold_left    = 0;
    logic hold_req     = 1'b0;

    energy_fir_level_meter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void clear_meter();
        int k;
        for (k = 0; k < TAPS; k++)
        begin
            sq_line[k]  = '0;
            coef_tab[k] = '0;
        end
        dec_phase = 0;
        bar_reg   = '0;
        thr_first = FIRST_THRESHOLD_RST;
        thr_step  = THRESHOLD_STEP_RST;
    endfunction

    // returns 1 when the beat closes a decimation block
    function automatic logic meter_step(input meter_in_t it, output reading_t rd);
        longint                  acc;
        longint                  thr;
        logic signed [ACC_W-1:0] energy;
        int                      k;
        rd = '0;
        if (it.op == OP_COEF)
        begin
            if (it.idx < TAPS)
                coef_tab[it.idx] = it.val;
            return 1'b0;
        end
        for (k = TAPS - 1; k > 0; k--)
            sq_line[k] = sq_line[k-1];
        sq_line[0] = it.smp * it.smp;
        dec_phase++;
        if (dec_phase < DECIMATION)
            return 1'b0;
        dec_phase = 0;
        acc = 0;
        for (k = 0; k < TAPS; k++)
            acc += longint'(sq_line[k]) * longint'(coef_tab[TAPS-1-k]);
        energy = acc[ACC_W-1:0];
        if (energy > 0)
        begin
            for (k = 0; k < 8; k++)
            begin
                thr = longint'(thr_first) + longint'(k) * longint'(thr_step);
                if (longint'(energy) > thr)
                begin
                    bar_reg = 8'hFF >> (7 - k);
                    rd.upd  = 1'b1;
                end
            end
        end
        rd.bar    = bar_reg;
        rd.energy = energy;
        return 1'b1;
    endfunction

    function automatic meter_in_t random_beat();
        meter_in_t it;
        it.op = ($urandom_range(0, 99) < 10) ? OP_COEF : OP_SAMPLE;
        case ($urandom_range(0, 9))
            0:       it.smp = '0;
            1:       it.smp = '1;
            2:       it.smp = SAMPLE_W'($urandom_range(0, 15));
            default: it.smp = SAMPLE_W'($urandom());
        endcase
        it.idx = ($urandom_range(0, 7) == 0) ? IDX_W'($urandom_range(TAPS, 63))
                                             : IDX_W'($urandom_range(0, TAPS - 1));
        it.val = ($urandom_range(0, 1) == 0) ? CVAL_W'($urandom())
                                             : CVAL_W'(int'($urandom_range(0, 16)) - 8);
        return it;
    endfunction

    task automatic send_beat(input meter_in_t it, input logic fixed, input reading_t fixed_rd);
        reading_t rd;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = it.op;
        s_axis_tdata  = {6'd0, it.val, it.idx, it.smp};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (meter_step(it, rd))
        begin
            readings_due.push_back(fixed ? fixed_rd : rd);
        end
        @(negedge clk);
    endtask

    task automatic drain_readings();
        s_axis_tvalid = 1'b0;
        while (readings_due.size() != 0)
            @(negedge clk);
        // a trailing walk may still be running
        repeat (TAPS + 20) @(negedge clk);
    endtask

    task automatic write_threshold(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] v);
        cfg_we    = 1'b1;
        cfg_index = which;
        cfg_data  = v;
        if (which == CFG_FIRST_THRESHOLD)
            thr_first = v;
        else
            thr_step = v;
        @(negedge clk);
    endtask

    initial
    begin : rx_side
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready = 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req      = 1'b0;
                hold_left     = HOLD_CYCLES;
                m_axis_tready = 1'b0;
            end
            else
                m_axis_tready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        reading_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (readings_due.size() == 0)
            begin
                $display("%0t: unexpected beat bar=%h energy=%0d updated=%b", $time,
                         m_axis_tdata[7:0], $signed(m_axis_tdata[55:8]), m_axis_tuser[0]);
                mismatch_cnt++;
            end
            else
            begin
                want = readings_due.pop_front();
                if (m_axis_tdata[7:0] !== want.bar)
                begin
                    $display("%0t: bar expected %h actual %h", $time, want.bar,
                             m_axis_tdata[7:0]);
                    mismatch_cnt++;
                end
                if ($signed(m_axis_tdata[55:8]) !== want.energy)
                begin
                    $display("%0t: energy expected %0d actual %0d", $time, want.energy,
                             $signed(m_axis_tdata[55:8]));
                    mismatch_cnt++;
                end
                if (m_axis_tuser[0] !== want.upd)
                begin
                    $display("%0t: bar_updated expected %b actual %b", $time, want.upd,
                             m_axis_tuser[0]);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial
    begin : stim
        reading_t              none;
        meter_in_t             it;
        logic [CFG_DATA_W-1:0] f;
        logic [CFG_DATA_W-1:0] s;
        int                    i;
        int                    r;
        int                    seg;
        int                    n;

        none          = '0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_FIRST_THRESHOLD;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_SAMPLE;
        clear_meter();

        // newest square meets coef 49, oldest meets coef 0
        dir_rows[0]  = '{'{OP_SAMPLE, 12'd4095, 6'd0, 16'sd0}, 50, 1'b1,
                         '{8'h00, 48'sd0, 1'b0}};
        dir_rows[1]  = '{'{OP_COEF, 12'd0, 6'd49, 16'sd1}, 1, 1'b0, '0};
        dir_rows[2]  = '{'{OP_COEF, 12'd0, 6'd0, -16'sd32768}, 1, 1'b0, '0};
        dir_rows[3]  = '{'{OP_COEF, 12'd0, 6'd50, 16'sd32767}, 1, 1'b0, '0};
        dir_rows[4]  = '{'{OP_COEF, 12'd0, 6'd63, -16'sd1}, 1, 1'b0, '0};
        dir_rows[5]  = '{'{OP_SAMPLE, 12'd0, 6'd0, 16'sd0}, 49, 1'b0, '0};
        dir_rows[6]  = '{'{OP_SAMPLE, 12'd100, 6'd0, 16'sd0}, 1, 1'b1,
                         '{8'h01, 48'sd10000, 1'b1}};
        dir_rows[7]  = '{'{OP_COEF, 12'd0, 6'd49, 16'sd32767}, 1, 1'b0, '0};
        dir_rows[8]  = '{'{OP_SAMPLE, 12'd4095, 6'd0, 16'sd0}, 50, 1'b1,
                         '{8'h01, -48'sd16769025, 1'b0}};
        dir_rows[9]  = '{'{OP_COEF, 12'd0, 6'd0, 16'sd0}, 1, 1'b0, '0};
        dir_rows[10] = '{'{OP_SAMPLE, 12'd4095, 6'd0, 16'sd0}, 50, 1'b1,
                         '{8'hFF, 48'sd549470642175, 1'b1}};
        dir_rows[11] = '{'{OP_COEF, 12'd0, 6'd25, -16'sd12345}, 1, 1'b0, '0};
        dir_rows[12] = '{'{OP_SAMPLE, 12'h555, 6'd0, 16'sd0}, 25, 1'b0, '0};
        dir_rows[13] = '{'{OP_SAMPLE, 12'hAAA, 6'd0, 16'sd0}, 25, 1'b0, '0};

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < 14; i++)
            for (r = 0; r < dir_rows[i].reps; r++)
                send_beat(dir_rows[i].beat, dir_rows[i].fixed && r == dir_rows[i].reps - 1,
                          dir_rows[i].rd);

        for (seg = 0; seg < 6; seg++)
        begin
            drain_readings();
            case (seg)
                0:
                begin
                    f = '0;
                    s = '0;
                end
                1:
                begin
                    f = '1;
                    s = '1;
                end
                2:
                begin
                    f = FIRST_THRESHOLD_RST;
                    s = THRESHOLD_STEP_RST;
                end
                3:
                begin
                    f = $urandom_range(0, 32'h3FFF_FFFF);
                    s = $urandom_range(0, 32'h0FFF_FFFF);
                end
                4:
                begin
                    f = '0;
                    s = $urandom();
                end
                default:
                begin
                    f = $urandom();
                    s = '0;
                end
            endcase
            write_threshold(CFG_FIRST_THRESHOLD, f);
            write_threshold(CFG_THRESHOLD_STEP, s);
            cfg_we = 1'b0;
            tx_idle_pct  = (seg < 2) ? 8 : (seg < 4) ? 72 : 0;
            rx_idle_pct  = (seg < 2) ? 72 : (seg < 4) ? 8 : 0;
            n = 0;
            while (n < 180)
            begin
                // long output stall while samples keep coming
                if (seg == 0 && n == 60)
                    hold_req = 1'b1;
                it = random_beat();
                send_beat(it, 1'b0, none);
                n++;
            end
        end

        drain_readings();
        if (mismatch_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
